// ===== rtl/core/led_strip_bit_encoder_top_defines.svh =====
`ifndef LED_STRIP_BIT_ENCODER_TOP_DEFINES_SVH
`define LED_STRIP_BIT_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, masked during reset
`define LSBE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsbe: implication check failed");

// next-cycle implication
`define LSBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsbe: next-cycle check failed");

`endif

// ===== rtl/core/lsbe_pkg.sv =====
package lsbe_pkg;

  localparam int unsigned BitsPerPixel     = 24;
  localparam int unsigned MaxLatch         = 64;
  localparam int unsigned DutyOutWidth     = 16;
  localparam int unsigned DutyWidthDefault = 16;
  localparam int unsigned CntWidth         = 7;
  localparam int unsigned CfgIdxWidth      = 2;
  localparam int unsigned CfgDataWidth     = 16;
  localparam int unsigned FifoDepthDefault = 2;

  localparam logic [7:0]          BrightnessReset = 8'd255;
  localparam logic [15:0]         OneDutyReset    = 16'd80;
  localparam logic [15:0]         ZeroDutyReset   = 16'd40;
  localparam logic [CntWidth-1:0] LatchSlotsReset = 7'd48;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgBrightness = 2'd0,
    CfgOneDuty    = 2'd1,
    CfgZeroDuty   = 2'd2,
    CfgLatchSlots = 2'd3
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OpPixel = 1'b0,
    OpLatch = 1'b1
  } op_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [DutyOutWidth-1:0] duty;
    logic                    last;
  } slot_out_t;

  typedef struct packed {
    logic                    is_latch;
    logic [BitsPerPixel-1:0] bits;
  } cmd_t;

endpackage

// ===== rtl/core/led_strip_bit_encoder_top.sv =====
// LED strip bit encoder. Each pixel word (operation = pixel) is scaled per color byte as
// (byte * brightness) >> 8, packed green-red-blue and sent out as 24 duty words, MSB first:
// one_duty for a 1 bit, zero_duty for a 0 bit (masked to DutyWidth bits). An end-of-frame
// word sends min(latch_slots, 64) zero-duty words, or none if latch_slots is 0. last marks
// the final duty word of each input word. The back end serializer emits one duty word per
// cycle while the receiver is ready; consecutive queued words stream without gaps. Input
// acceptance runs ahead through a scaling register and a two-entry queue; a pixel passes
// the scaling register, the queue and the back-end shift register before its first duty
// word is registered at the output. Write configuration only while the block is idle.
module led_strip_bit_encoder_top
  import lsbe_pkg::*;
#(
  parameter int unsigned DutyWidth = DutyWidthDefault,
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pix_in_t                 in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output slot_out_t               out_word_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  logic [7:0]           brightness_q;
  logic [DutyWidth-1:0] one_duty_q, zero_duty_q;
  logic [CntWidth-1:0]  latch_slots_q;
  logic                 f_valid, f_ready, q_valid, q_pop;
  cmd_t                 f_cmd, q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q  <= BrightnessReset;
      one_duty_q    <= DutyWidth'(OneDutyReset);
      zero_duty_q   <= DutyWidth'(ZeroDutyReset);
      latch_slots_q <= LatchSlotsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgBrightness: brightness_q  <= cfg_data_i[7:0];
        CfgOneDuty:    one_duty_q    <= cfg_data_i[DutyWidth-1:0];
        CfgZeroDuty:   zero_duty_q   <= cfg_data_i[DutyWidth-1:0];
        CfgLatchSlots: latch_slots_q <= cfg_data_i[CntWidth-1:0];
        default: ;
      endcase
    end
  end

  lsbe_front u_front (
    .clk_i,
    .rst_ni,
    .brightness_i (brightness_q),
    .in_valid_i,
    .in_ready_o,
    .in_word_i,
    .cmd_valid_o  (f_valid),
    .cmd_ready_i  (f_ready),
    .cmd_o        (f_cmd)
  );

  lsbe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_i       (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_o        (q_cmd)
  );

  lsbe_back #(
    .DutyWidth (DutyWidth)
  ) u_back (
    .clk_i,
    .rst_ni,
    .one_duty_i    (one_duty_q),
    .zero_duty_i   (zero_duty_q),
    .latch_slots_i (latch_slots_q),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .cmd_pop_o     (q_pop),
    .out_valid_o,
    .out_ready_i,
    .out_word_o
  );

endmodule

// ===== rtl/core/lsbe_front.sv =====
module lsbe_front
  import lsbe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] brightness_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pix_in_t    in_word_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  logic        vld_q, vld_d;
  cmd_t        cmd_q, cmd_d;
  logic        accept;
  logic [15:0] prod_r, prod_g, prod_b;

  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  assign prod_r = 16'(in_word_i.red)   * 16'(brightness_i);
  assign prod_g = 16'(in_word_i.green) * 16'(brightness_i);
  assign prod_b = 16'(in_word_i.blue)  * 16'(brightness_i);

  always_comb begin
    cmd_d.is_latch = (in_word_i.operation == OpLatch);
    cmd_d.bits     = {prod_g[15:8], prod_r[15:8], prod_b[15:8]};
    vld_d          = accept || (vld_q && !cmd_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== rtl/core/lsbe_fifo.sv =====
`include "led_strip_bit_encoder_top_defines.svh"

module lsbe_fifo
  import lsbe_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output cmd_t pop_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW     = $clog2(Depth + 1);

  cmd_t                mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  `LSBE_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(Depth))
  `LSBE_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1)
  `LSBE_ASSERT_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

// ===== rtl/core/lsbe_back.sv =====
`include "led_strip_bit_encoder_top_defines.svh"

module lsbe_back
  import lsbe_pkg::*;
#(
  parameter int unsigned DutyWidth = DutyWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [DutyWidth-1:0] one_duty_i,
  input  logic [DutyWidth-1:0] zero_duty_i,
  input  logic [CntWidth-1:0]  latch_slots_i,
  input  logic                 cmd_valid_i,
  input  cmd_t                 cmd_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output slot_out_t            out_word_o
);

  logic                    busy_q, busy_d;
  logic                    latch_q, latch_d;
  logic [BitsPerPixel-1:0] bits_q, bits_d;
  logic [CntWidth-1:0]     cnt_q, cnt_d;
  logic                    out_vld_q, out_vld_d;
  slot_out_t               out_q, out_d;
  logic                    advance, final_slot, pop;
  logic [CntWidth-1:0]     latch_n;
  logic [DutyWidth-1:0]    duty_sel;

  assign latch_n    = (latch_slots_i > CntWidth'(MaxLatch)) ? CntWidth'(MaxLatch)
                                                            : latch_slots_i;
  assign advance    = busy_q && (!out_vld_q || out_ready_i);
  assign final_slot = (cnt_q == CntWidth'(1));
  assign pop        = cmd_valid_i && (!busy_q || (advance && final_slot));
  assign cmd_pop_o  = pop;
  assign duty_sel   = latch_q ? '0 : (bits_q[BitsPerPixel-1] ? one_duty_i : zero_duty_i);

  always_comb begin
    busy_d    = busy_q;
    latch_d   = latch_q;
    bits_d    = bits_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (advance) begin
      out_vld_d      = 1'b1;
      out_d.duty     = DutyOutWidth'(duty_sel);
      out_d.last     = final_slot;
      bits_d         = {bits_q[BitsPerPixel-2:0], 1'b0};
      cnt_d          = cnt_q - 1'b1;
      busy_d         = !final_slot;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (pop) begin
      latch_d = cmd_i.is_latch;
      bits_d  = cmd_i.bits;
      if (cmd_i.is_latch) begin
        cnt_d  = latch_n;
        busy_d = (latch_n != '0);
      end else begin
        cnt_d  = CntWidth'(BitsPerPixel);
        busy_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    latch_q <= latch_d;
    bits_q  <= bits_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  `LSBE_ASSERT_IMPL(a_busy_cnt, busy_q, (cnt_q != '0) && (cnt_q <= CntWidth'(MaxLatch)))
  `LSBE_ASSERT_IMPL(a_pop_gap, pop, !busy_q || (advance && final_slot))
  `LSBE_ASSERT_NEXT(a_pix_len, pop && !cmd_i.is_latch, busy_q && (cnt_q == CntWidth'(BitsPerPixel)))
  `LSBE_ASSERT_NEXT(a_last_ends, advance && final_slot && !pop, !busy_q)

endmodule

// ===== test/led_strip_bit_encoder_top_tb.sv =====
`timescale 1ns / 1ps

module led_strip_bit_encoder_top_tb;
  import lsbe_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumRows    = 23;
  localparam int unsigned NumPhases  = 5;
  localparam int unsigned PhaseWords = 25;

  typedef struct packed {
    logic        cfg_en;
    cfg_reg_e    cfg_idx;
    logic [15:0] cfg_val;
    op_e         op;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        fixed;
    logic [23:0] grb;
  } plan_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  pix_in_t                 in_word_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  slot_out_t               out_word_o;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;

  // register mirror
  logic [7:0]          bright_q;
  logic [15:0]         one_q;
  logic [15:0]         zero_q;
  logic [CntWidth-1:0] latch_q;

  slot_out_t   expected_slots[$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned hold_len;
  logic        in_gaps;
  logic        out_gaps;
  logic        fixed_en;
  logic [23:0] fixed_grb;

  // fixed rows: expected GRB word typed in (reset config unless a write precedes)
  plan_row_t plan [NumRows] = '{
    '{1'b0, CfgBrightness, 16'h0000, OpPixel, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
    '{1'b0, CfgBrightness, 16'h0000, OpPixel, 8'hff, 8'hff, 8'hff, 1'b1, 24'hfefefe},
    '{1'b0, CfgBrightness, 16'h0000, OpPixel, 8'hff, 8'h00, 8'h00, 1'b1, 24'h00fe00},
    '{1'b0, CfgBrightness, 16'h0000, OpPixel, 8'h00, 8'hff, 8'h00, 1'b1, 24'hfe0000},
    '{1'b0, CfgBrightness, 16'h0000, OpPixel, 8'h00, 8'h00, 8'hff, 1'b1, 24'h0000fe},
    '{1'b0, CfgBrightness, 16'h0000, OpPixel, 8'h80, 8'h01, 8'h7f, 1'b0, 24'h000000},
    '{1'b0, CfgBrightness, 16'h0000, OpPixel, 8'haa, 8'h55, 8'hc3, 1'b0, 24'h000000},
    '{1'b0, CfgBrightness, 16'h0000, OpLatch, 8'hff, 8'hff, 8'hff, 1'b0, 24'h000000},
    '{1'b1, CfgBrightness, 16'hff00, OpPixel, 8'hff, 8'hff, 8'hff, 1'b1, 24'h000000},
    '{1'b0, CfgBrightness, 16'h0000, OpPixel, 8'h12, 8'h34, 8'h56, 1'b1, 24'h000000},
    '{1'b1, CfgBrightness, 16'h0080, OpPixel, 8'hff, 8'hff, 8'hff, 1'b1, 24'h7f7f7f},
    '{1'b1, CfgBrightness, 16'h0001, OpPixel, 8'hff, 8'hff, 8'hff, 1'b1, 24'h000000},
    '{1'b1, CfgOneDuty,    16'hffff, OpPixel, 8'ha5, 8'h5a, 8'h3c, 1'b0, 24'h000000},
    '{1'b1, CfgZeroDuty,   16'h0000, OpPixel, 8'h0f, 8'hf0, 8'h99, 1'b0, 24'h000000},
    '{1'b1, CfgLatchSlots, 16'h0000, OpLatch, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{1'b0, CfgBrightness, 16'h0000, OpPixel, 8'hff, 8'h00, 8'hff, 1'b0, 24'h000000},
    '{1'b1, CfgLatchSlots, 16'h0001, OpLatch, 8'h5a, 8'ha5, 8'h0f, 1'b0, 24'h000000},
    '{1'b1, CfgLatchSlots, 16'h0040, OpLatch, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{1'b1, CfgLatchSlots, 16'hffc1, OpLatch, 8'hff, 8'hff, 8'hff, 1'b0, 24'h000000},
    '{1'b1, CfgLatchSlots, 16'h007f, OpLatch, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{1'b1, CfgBrightness, 16'h00ff, OpPixel, 8'h01, 8'h02, 8'h03, 1'b0, 24'h000000},
    '{1'b1, CfgOneDuty,    16'h0000, OpPixel, 8'hff, 8'hff, 8'hff, 1'b0, 24'h000000},
    '{1'b1, CfgZeroDuty,   16'hffff, OpPixel, 8'h00, 8'hff, 8'h00, 1'b0, 24'h000000}
  };

  led_strip_bit_encoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] dim(input logic [7:0] c);
    logic [15:0] prod;
    prod = 16'(c) * 16'(bright_q);
    return prod[15:8];
  endfunction

  function automatic logic [23:0] pack_grb(input pix_in_t w);
    return {dim(w.green), dim(w.red), dim(w.blue)};
  endfunction

  function automatic void queue_pixel_slots(input logic [23:0] grb);
    slot_out_t s;
    for (int k = BitsPerPixel - 1; k >= 0; k--) begin
      s.duty = grb[k] ? one_q : zero_q;
      s.last = (k == 0);
      expected_slots.push_back(s);
    end
  endfunction

  function automatic void queue_latch_slots();
    int unsigned n;
    slot_out_t   s;
    n = (latch_q > CntWidth'(MaxLatch)) ? MaxLatch : 32'(latch_q);
    for (int unsigned k = 0; k < n; k++) begin
      s.duty = '0;
      s.last = (k + 1 == n);
      expected_slots.push_back(s);
    end
  endfunction

  function automatic void note_error(input string msg);
    if (err_cnt < 10) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    err_cnt++;
  endfunction

  function automatic void check_slot(input slot_out_t got);
    slot_out_t want;
    if (expected_slots.size() == 0) begin
      note_error($sformatf("unexpected word: duty %h last %b", got.duty, got.last));
      return;
    end
    want = expected_slots.pop_front();
    if (got.duty !== want.duty) begin
      note_error($sformatf("duty: exp %h got %h", want.duty, got.duty));
    end
    if (got.last !== want.last) begin
      note_error($sformatf("last: exp %b got %b", want.last, got.last));
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (in_word_i.operation == OpLatch) begin
          queue_latch_slots();
        end else begin
          queue_pixel_slots(fixed_en ? fixed_grb : pack_grb(in_word_i));
        end
      end
      if (out_valid_o && out_ready_i) begin
        check_slot(out_word_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("led_strip_bit_encoder_top_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
        out_ready_i <= 1'b1;
      end else if (out_gaps && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_word(input pix_in_t w);
    int unsigned gap;
    gap = (in_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CfgBrightness: bright_q = val[7:0];
      CfgOneDuty:    one_q    = val;
      CfgZeroDuty:   zero_q   = val;
      CfgLatchSlots: latch_q  = val[CntWidth-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // a zero-slot latch word may still be in flight when the queue empties
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_slots.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    pix_in_t w;
    logic    last_phase;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CfgBrightness;
    cfg_data_i  = '0;
    bright_q    = BrightnessReset;
    one_q       = OneDutyReset;
    zero_q      = ZeroDutyReset;
    latch_q     = LatchSlotsReset;
    err_cnt     = 0;
    cycle_cnt   = 0;
    hold_len    = 0;
    in_gaps     = 1'b1;
    out_gaps    = 1'b1;
    fixed_en    = 1'b0;
    fixed_grb   = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      if (plan[i].cfg_en) begin
        wait_idle();
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
        cfg_we_i <= 1'b0;
      end
      w.operation = plan[i].op;
      w.red       = plan[i].red;
      w.green     = plan[i].green;
      w.blue      = plan[i].blue;
      fixed_en    = plan[i].fixed;
      fixed_grb   = plan[i].grb;
      send_word(w);
    end
    fixed_en = 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      case (p)
        1: begin
          write_reg(CfgBrightness, 16'h00ff);
          write_reg(CfgOneDuty, 16'hffff);
          write_reg(CfgZeroDuty, 16'h0000);
          write_reg(CfgLatchSlots, 16'd64);
        end
        2: begin
          write_reg(CfgBrightness, 16'h0000);
          write_reg(CfgOneDuty, 16'h0000);
          write_reg(CfgZeroDuty, 16'hffff);
          write_reg(CfgLatchSlots, 16'd0);
        end
        default: begin
          write_reg(CfgBrightness, 16'($urandom));
          write_reg(CfgOneDuty, 16'($urandom));
          write_reg(CfgZeroDuty, 16'($urandom));
          write_reg(CfgLatchSlots,
                    {9'($urandom), 7'($urandom_range(0, (p == 3) ? 127 : 24))});
        end
      endcase
      cfg_we_i <= 1'b0;
      last_phase = (p == NumPhases - 1);
      in_gaps    = !last_phase && (p != 1);
      out_gaps   = !last_phase;
      // long receiver hold-off while the sender keeps pushing
      if (p == 1) begin
        hold_len = 160;
      end
      for (int i = 0; i < PhaseWords; i++) begin
        w.operation = ($urandom_range(0, 7) == 0) ? OpLatch : OpPixel;
        w.red       = rand_byte();
        w.green     = rand_byte();
        w.blue      = rand_byte();
        send_word(w);
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("led_strip_bit_encoder_top_tb: done, clean");
    end else begin
      $display("led_strip_bit_encoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
